[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check on every clock edge outside reset
`define DSFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define DSFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DSFC_ASSERT(lbl, prop, msg)
`define DSFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/dsfc_pkg.sv]
// shared constants and types for the dual s-box stream cipher core
package dsfc_pkg;
    localparam int BOX_W         = 8;
    localparam int BOX_AW        = 8;
    localparam int MIX_ROUNDS    = 3;
    localparam int MAX_KEY_BYTES = 32;
    localparam int HASH_BYTES    = 32;
    localparam int KLEN_W        = 6;
    localparam int KIDX_W        = 5;
    localparam int ROUND_W       = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
    localparam int HASH_W        = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int OP_W          = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_KEY    = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA   = 2'd1;
    localparam logic [OP_W-1:0] OP_HASH   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 3'd5;

    // one access request to a box memory
    typedef struct packed {
        logic              we;
        logic [BOX_AW-1:0] waddr;
        logic [BOX_W-1:0]  wdata;
        logic              re;
        logic [BOX_AW-1:0] raddr;
    } t_box_req;
endpackage

[src/dsfc_box_ram.sv]
// 256 x 8 s-box memory, one write and one registered read per cycle
module dsfc_box_ram (
    input  logic                         i_clk,
    input  dsfc_pkg::t_box_req           i_req,
    output logic [dsfc_pkg::BOX_W-1:0]   o_rdata
);
    import dsfc_pkg::*;

    logic [BOX_W-1:0] r_mem [2**BOX_AW];
    logic [BOX_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/dual_sbox_feedback_stream_cipher_core.sv]
// top level: sequencer, key registers and output stage of the stream cipher
//
//  channel  | valid / ready             | payload
//  ---------+---------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready   | i_opcode, i_data_byte
//  output   | o_out_valid / i_out_ready | o_out_byte, o_is_hash, o_last
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a data request runs through nine dependent steps, S_K1 to S_K9, through the
// single read port of each box memory, after the idle state takes it in.
// a hash request runs the same steps once per hash byte, 32 bytes in all.
// the key schedule fills all 256 entries of both boxes, then does 2 x 3 x 256
// swaps, each through S_MRD, S_MRUN, S_MW1 and S_MW2, then loads the pointers.
// a waiting result stalls the sequencer only when the next one is ready.
// reset is synchronous and clears control state and the pointers.
module dual_sbox_feedback_stream_cipher_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dsfc_pkg::OP_W-1:0]           i_opcode,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_out_byte,
    output logic                                o_is_hash,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dsfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dsfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dsfc_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_MRD  = 4'd2;
    localparam logic [3:0] S_MRUN = 4'd3;
    localparam logic [3:0] S_MW1  = 4'd4;
    localparam logic [3:0] S_MW2  = 4'd5;
    localparam logic [3:0] S_PL   = 4'd6;
    localparam logic [3:0] S_K1   = 4'd7;
    localparam logic [3:0] S_K2   = 4'd8;
    localparam logic [3:0] S_K3   = 4'd9;
    localparam logic [3:0] S_K4   = 4'd10;
    localparam logic [3:0] S_K5   = 4'd11;
    localparam logic [3:0] S_K6   = 4'd12;
    localparam logic [3:0] S_K7   = 4'd13;
    localparam logic [3:0] S_K8   = 4'd14;
    localparam logic [3:0] S_K9   = 4'd15;

    localparam logic [BOX_AW-1:0]  X_LAST     = BOX_AW'(2**BOX_AW - 1);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(MIX_ROUNDS - 1);
    localparam logic [HASH_W-1:0]  HASH_LAST  = HASH_W'(HASH_BYTES - 1);
    localparam logic [KLEN_W-1:0]  KLEN_MAX   = KLEN_W'(MAX_KEY_BYTES);

    // configuration
    logic [CFG_DATA_W-1:0] r_key [4];
    logic [KLEN_W-1:0]     r_klen;
    logic                  r_decrypt;

    // sequencer state
    logic [3:0]         r_state, n_state;
    logic [BOX_AW-1:0]  r_x, n_x;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [KIDX_W-1:0]  r_kidx, n_kidx;
    logic [KIDX_W-1:0]  r_kstart, n_kstart;
    logic               r_mixb, n_mixb;
    logic [BOX_W-1:0]   r_run, n_run;
    logic [BOX_W-1:0]   r_ax, n_ax;
    logic [BOX_W-1:0]   r_bi, n_bi;
    logic [HASH_W-1:0]  r_hcnt, n_hcnt;
    logic               r_hash, n_hash;
    logic [7:0]         r_data, n_data;
    logic [BOX_W-1:0]   r_pi, n_pi, r_pj, n_pj, r_pi2, n_pi2, r_pj2, n_pj2;

    // output stage
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_is_hash, n_is_hash;
    logic               r_last, n_last;

    t_box_req           a_req, b_req, m_req;
    logic [BOX_W-1:0]   a_rdata, b_rdata, m_rdata;
    logic [BOX_W-1:0]   kbyte;
    logic [KIDX_W-1:0]  kidx_inc;
    logic [KIDX_W-1:0]  kstart_inc;
    logic               out_free;
    logic [BOX_W-1:0]   kout;
    logic               in_acc;

    dsfc_box_ram u_box_a (.i_clk(i_clk), .i_req(a_req), .o_rdata(a_rdata));
    dsfc_box_ram u_box_b (.i_clk(i_clk), .i_req(b_req), .o_rdata(b_rdata));

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // configuration writes, key length saturated on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]  <= '0;
            r_key[1]  <= '0;
            r_key[2]  <= '0;
            r_key[3]  <= '0;
            r_klen    <= KLEN_W'(1);
            r_decrypt <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY0: r_key[0] <= i_cfg_data;
                REG_KEY1: r_key[1] <= i_cfg_data;
                REG_KEY2: r_key[2] <= i_cfg_data;
                REG_KEY3: r_key[3] <= i_cfg_data;
                REG_KEY_LEN: begin
                    if (i_cfg_data[KLEN_W-1:0] == '0) begin
                        r_klen <= KLEN_W'(1);
                    end else if (i_cfg_data[KLEN_W-1:0] > KLEN_MAX) begin
                        r_klen <= KLEN_MAX;
                    end else begin
                        r_klen <= i_cfg_data[KLEN_W-1:0];
                    end
                end
                REG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // key byte pick and key index wrap
    assign kbyte      = r_key[r_kidx[4:3]][{r_kidx[2:0], 3'b000} +: 8];
    assign kidx_inc   = ({1'b0, r_kidx} + 6'd1 == r_klen) ? '0 : r_kidx + 1'b1;
    assign kstart_inc = ({1'b0, r_kstart} + 6'd1 == r_klen) ? '0 : r_kstart + 1'b1;
    assign m_rdata    = r_mixb ? b_rdata : a_rdata;
    assign kout       = r_hash ? b_rdata - 8'd1
                      : (r_decrypt ? r_data - b_rdata : r_data + b_rdata);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_round     = r_round;
        n_kidx      = r_kidx;
        n_kstart    = r_kstart;
        n_mixb      = r_mixb;
        n_run       = r_run;
        n_ax        = r_ax;
        n_bi        = r_bi;
        n_hcnt      = r_hcnt;
        n_hash      = r_hash;
        n_data      = r_data;
        n_pi        = r_pi;
        n_pj        = r_pj;
        n_pi2       = r_pi2;
        n_pj2       = r_pj2;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_is_hash   = r_is_hash;
        n_last      = r_last;
        a_req       = '0;
        b_req       = '0;
        m_req       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_data = i_data_byte;
                    n_hcnt = '0;
                    unique case (i_opcode)
                        OP_KEY: begin
                            n_state = S_FILL;
                            n_x     = '0;
                        end
                        OP_DATA: begin
                            n_state = S_K1;
                            n_hash  = 1'b0;
                        end
                        OP_HASH: begin
                            n_state = S_K1;
                            n_hash  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // preset both boxes
            S_FILL: begin
                a_req.we    = 1'b1;
                a_req.waddr = r_x;
                a_req.wdata = r_x + BOX_W'(r_klen);
                b_req.we    = 1'b1;
                b_req.waddr = r_x;
                b_req.wdata = r_x;
                n_x         = r_x + 1'b1;
                if (r_x == X_LAST) begin
                    n_state  = S_MRD;
                    n_round  = '0;
                    n_kidx   = '0;
                    n_kstart = '0;
                    n_run    = '0;
                    n_mixb   = 1'b0;
                end
            end
            // mixing swap, shared by both boxes
            S_MRD: begin
                m_req.re    = 1'b1;
                m_req.raddr = r_x;
                n_state     = S_MRUN;
            end
            S_MRUN: begin
                n_ax        = m_rdata;
                n_run       = r_run + m_rdata + kbyte;
                m_req.re    = 1'b1;
                m_req.raddr = n_run;
                n_state     = S_MW1;
            end
            S_MW1: begin
                m_req.we    = 1'b1;
                m_req.waddr = r_x;
                m_req.wdata = m_rdata;
                n_state     = S_MW2;
            end
            S_MW2: begin
                m_req.we    = 1'b1;
                m_req.waddr = r_run;
                m_req.wdata = r_ax;
                n_kidx      = kidx_inc;
                n_x         = r_x + 1'b1;
                n_state     = S_MRD;
                if (r_x == X_LAST) begin
                    if (r_round == ROUND_LAST) begin
                        n_round = '0;
                        if (!r_mixb) begin
                            n_mixb   = 1'b1;
                            n_kidx   = '0;
                            n_kstart = '0;
                        end else begin
                            n_state = S_PL;
                        end
                    end else begin
                        n_round = r_round + 1'b1;
                        if (r_mixb) begin
                            n_kstart = kstart_inc;
                            n_kidx   = kstart_inc;
                        end else begin
                            n_kidx = '0;
                        end
                    end
                end
            end
            // pointer load from box a entries 0, 1, 2 and 255
            S_PL: begin
                a_req.re = (r_x < 8'd4);
                case (r_x)
                    8'd0:    a_req.raddr = 8'd0;
                    8'd1:    a_req.raddr = 8'd1;
                    8'd2:    a_req.raddr = 8'd2;
                    default: a_req.raddr = X_LAST;
                endcase
                case (r_x)
                    8'd1:    n_pi  = a_rdata;
                    8'd2:    n_pj  = a_rdata;
                    8'd3:    n_pi2 = a_rdata;
                    8'd4:    n_pj2 = a_rdata;
                    default: ;
                endcase
                n_x = r_x + 1'b1;
                if (r_x == 8'd4) begin
                    n_state = S_IDLE;
                end
            end
            // keystream step
            S_K1: begin
                n_pi        = r_pi + 1'b1;
                a_req.re    = 1'b1;
                a_req.raddr = n_pi;
                b_req.re    = 1'b1;
                b_req.raddr = n_pi;
                n_state     = S_K2;
            end
            S_K2: begin
                n_pj        = r_pj + a_rdata;
                n_bi        = b_rdata;
                a_req.re    = 1'b1;
                a_req.raddr = n_pj;
                b_req.re    = 1'b1;
                b_req.raddr = n_pj;
                n_state     = S_K3;
            end
            S_K3: begin
                n_pi2       = r_pi2 + a_rdata;
                a_req.re    = 1'b1;
                a_req.raddr = n_pi2;
                b_req.we    = !r_hash;
                b_req.waddr = r_pi;
                b_req.wdata = b_rdata;
                n_state     = S_K4;
            end
            S_K4: begin
                n_ax        = a_rdata;
                n_pj2       = r_pj2 + a_rdata;
                a_req.re    = 1'b1;
                a_req.raddr = n_pj2;
                b_req.we    = !r_hash;
                b_req.waddr = r_pj;
                b_req.wdata = r_bi;
                n_state     = S_K5;
            end
            S_K5: begin
                n_run       = r_ax + a_rdata;
                a_req.we    = 1'b1;
                a_req.waddr = r_pi2;
                a_req.wdata = a_rdata;
                n_state     = S_K6;
            end
            S_K6: begin
                a_req.we    = 1'b1;
                a_req.waddr = r_pj2;
                a_req.wdata = r_ax;
                n_state     = S_K7;
            end
            S_K7: begin
                a_req.re    = 1'b1;
                a_req.raddr = r_run;
                n_state     = S_K8;
            end
            S_K8: begin
                b_req.re    = 1'b1;
                b_req.raddr = a_rdata;
                n_state     = S_K9;
            end
            // result into the output stage once it is free
            S_K9: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = kout;
                    n_is_hash   = r_hash;
                    if (r_hash) begin
                        n_last = (r_hcnt == HASH_LAST);
                        if (r_hcnt == HASH_LAST) begin
                            n_state = S_IDLE;
                        end else begin
                            n_hcnt  = r_hcnt + 1'b1;
                            n_state = S_K1;
                        end
                    end else begin
                        n_last  = 1'b1;
                        n_pj    = r_pj ^ (r_decrypt ? r_data : kout);
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (r_state == S_MRD || r_state == S_MRUN || r_state == S_MW1
                || r_state == S_MW2) begin
            if (r_mixb) begin
                b_req = m_req;
            end else begin
                a_req = m_req;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hcnt      <= '0;
            r_pi        <= '0;
            r_pj        <= '0;
            r_pi2       <= '0;
            r_pj2       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hcnt      <= n_hcnt;
            r_pi        <= n_pi;
            r_pj        <= n_pj;
            r_pi2       <= n_pi2;
            r_pj2       <= n_pj2;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_round    <= n_round;
        r_kidx     <= n_kidx;
        r_kstart   <= n_kstart;
        r_mixb     <= n_mixb;
        r_run      <= n_run;
        r_ax       <= n_ax;
        r_bi       <= n_bi;
        r_hash     <= n_hash;
        r_data     <= n_data;
        r_out_byte <= n_out_byte;
        r_is_hash  <= n_is_hash;
        r_last     <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_hash   = r_is_hash;
    assign o_last      = r_last;

    // checks
    `DSFC_ASSERT(a_data_busy, (in_acc && i_opcode == OP_DATA) |=> !o_in_ready, "data request not held busy")
    `DSFC_ASSERT(a_klen_range, (r_klen >= KLEN_W'(1)) && (r_klen <= KLEN_MAX), "key length out of range")
    `DSFC_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte) && $stable(o_is_hash) && $stable(o_last)), "waiting result not held")
endmodule

[bench/dsfc_stream_checker.sv]
// checker for the dual s-box stream cipher core: own cipher state, expected byte queue, compare
module dsfc_stream_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [dsfc_pkg::OP_W-1:0]      i_opcode,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_is_hash,
    input  logic                           i_last,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [dsfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dsfc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_hash;
        logic       last;
    } t_cipher_byte;

    // shadow copy of the key registers and cipher state
    logic [63:0]       key_word [4];
    logic [KLEN_W-1:0] key_len;
    logic              decrypt;
    logic [7:0]        box_a [256];
    logic [7:0]        box_b [256];
    logic [7:0]        pi, pj, pi2, pj2;

    t_cipher_byte expected_bytes [$];
    int fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_bytes.size();

    function automatic logic [7:0] key_byte(input int k);
        k = k & 31;
        return key_word[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    // key schedule: preset both boxes, mix with one shared running index
    task automatic run_key_schedule();
        int n;
        logic [7:0] run;
        logic [7:0] t;
        n = key_len;
        if (n == 0) n = 1;
        if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
        for (int x = 0; x < 256; x++) begin
            box_a[x] = 8'(x + n);
            box_b[x] = 8'(x);
        end
        run = '0;
        for (int r = 0; r < MIX_ROUNDS; r++) begin
            for (int x = 0; x < 256; x++) begin
                run = run + box_a[x] + key_byte(x % n);
                t = box_a[x];
                box_a[x] = box_a[run];
                box_a[run] = t;
            end
        end
        for (int r = 0; r < MIX_ROUNDS; r++) begin
            for (int x = 0; x < 256; x++) begin
                run = run + box_b[x] + key_byte((x + r) % n);
                t = box_b[x];
                box_b[x] = box_b[run];
                box_b[run] = t;
            end
        end
        pi  = box_a[0];
        pj  = box_a[1];
        pi2 = box_a[2];
        pj2 = box_a[255];
    endtask

    // advance the pointers, swap, and return one keystream byte
    function automatic logic [7:0] next_keystream(input logic swap_b);
        logic [7:0] sel;
        logic [7:0] t;
        pi  = pi + 8'd1;
        pj  = pj + box_a[pi];
        pi2 = pi2 + box_a[pj];
        pj2 = pj2 + box_a[pi2];
        if (swap_b) begin
            t = box_b[pi];
            box_b[pi] = box_b[pj];
            box_b[pj] = t;
        end
        sel = box_a[pi2] + box_a[pj2];
        t = box_a[pi2];
        box_a[pi2] = box_a[pj2];
        box_a[pj2] = t;
        return box_b[box_a[sel]];
    endfunction

    // work out the bytes one accepted request causes
    task automatic predict_request(input logic [OP_W-1:0] op, input logic [7:0] d);
        logic [7:0] k;
        logic [7:0] o;
        case (op)
            OP_KEY: run_key_schedule();
            OP_DATA: begin
                k = next_keystream(1'b1);
                if (decrypt) begin
                    o = d - k;
                    pj = pj ^ d;
                end else begin
                    o = d + k;
                    pj = pj ^ o;
                end
                expected_bytes.push_back('{o, 1'b0, 1'b1});
            end
            OP_HASH: begin
                for (int n = 0; n < HASH_BYTES; n++) begin
                    k = next_keystream(1'b0);
                    expected_bytes.push_back('{k - 8'd1, 1'b1, n == HASH_BYTES - 1});
                end
            end
            default: ;
        endcase
    endtask

    // compare outputs first, then take in config writes and requests
    always @(posedge i_clk) begin
        t_cipher_byte exp_b;
        if (!i_rst_n) begin
            for (int w = 0; w < 4; w++) key_word[w] = '0;
            key_len = KLEN_W'(1);
            decrypt = 1'b0;
            pi = '0; pj = '0; pi2 = '0; pj2 = '0;
            expected_bytes.delete();
            fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output byte %h", i_out_byte);
                    fail_count++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (i_out_byte !== exp_b.out_byte) begin
                        $error("out_byte expected %h actual %h", exp_b.out_byte, i_out_byte);
                        fail_count++;
                    end
                    if (i_is_hash !== exp_b.is_hash) begin
                        $error("is_hash expected %b actual %b", exp_b.is_hash, i_is_hash);
                        fail_count++;
                    end
                    if (i_last !== exp_b.last) begin
                        $error("last expected %b actual %b", exp_b.last, i_last);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                        key_word[i_cfg_index[1:0]] = i_cfg_data;
                    REG_KEY_LEN: key_len = i_cfg_data[KLEN_W-1:0];
                    REG_DECRYPT: decrypt = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_request(i_opcode, i_data_byte);
        end
    end
endmodule

[bench/tb_dual_sbox_feedback_stream_cipher_core.sv]
// testbench top for the dual s-box stream cipher core: stimulus, watchdog and verdict
module tb_dual_sbox_feedback_stream_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dsfc_pkg::*;

    localparam int KEY_SCHED_WAIT = 7000;
    localparam int STALL_LIMIT    = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode = OP_KEY;
    logic [7:0]            data_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  is_hash;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;

    bit calm;
    bit silent_tail;
    int reply_stall;
    int quiet_cycles;

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    dual_sbox_feedback_stream_cipher_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_opcode(opcode), .i_data_byte(data_byte),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_byte(out_byte), .o_is_hash(is_hash), .o_last(last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    dsfc_stream_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_opcode(opcode), .i_data_byte(data_byte),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_byte(out_byte), .i_is_hash(is_hash), .i_last(last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls: a fresh wait drawn after every accepted byte
    always @(posedge clk) begin
        if (out_valid && out_ready)
            reply_stall = calm ? 0 : $urandom_range(0, 7);
    end

    always @(negedge clk) begin
        if (reply_stall > 0) begin
            out_ready <= 1'b0;
            reply_stall--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one cipher request, called and left at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= d;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        silent_tail = (op != OP_DATA) && (op != OP_HASH);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // wait for every expected byte, plus the key schedule's run time if needed
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        @(negedge clk);
        repeat (silent_tail ? KEY_SCHED_WAIT : 20) @(negedge clk);
        silent_tail = 1'b0;
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [5:0] klen, input logic dec);
        settle();
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_KEY_LEN, 64'(klen));
        write_reg(REG_DECRYPT, 64'(dec));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int r;
        logic [5:0] klen;
        reply_stall = 0;
        silent_tail = 1'b0;
        calm = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero key length, extremes of bytes, ignored opcode, hash
        load_key('0, '0, '0, '0, 6'd0, 1'b0);
        send_request(OP_UNUSED, 8'hA5);
        send_request(OP_KEY, 8'hFF);
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_DATA, 8'h5A);
        send_request(OP_UNUSED, 8'hFF);
        send_request(OP_HASH, 8'hFF);
        send_request(OP_DATA, 8'hA5);

        // directed: full key length of all ones, decrypt
        load_key('1, '1, '1, '1, 6'd32, 1'b1);
        send_request(OP_KEY, 8'h00);
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_HASH, 8'h00);
        send_request(OP_DATA, 8'h81);

        // directed: key length above the maximum saturates
        load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, '1, '0, 6'd63, 1'b0);
        send_request(OP_KEY, 8'h3C);
        send_request(OP_DATA, 8'h7E);
        send_request(OP_HASH, 8'h11);

        // random phases, each with a new key and mode
        for (int phase = 0; phase < 8; phase++) begin
            r = $urandom_range(0, 9);
            klen = (r == 0) ? 6'd1 : (r == 1) ? 6'd32 : (r == 2) ? 6'd0 : (r == 3) ? 6'd63
                 : 6'($urandom_range(1, 32));
            load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, klen, 1'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 3) == 0);
            send_request(OP_KEY, 8'($urandom));
            for (int n = 0; n < 46; n++) begin
                r = $urandom_range(0, 99);
                if (r < 78)
                    send_request(OP_DATA, 8'($urandom));
                else if (r < 88)
                    send_request(OP_HASH, 8'($urandom));
                else if (r < 95)
                    send_request(OP_UNUSED, 8'($urandom));
                else
                    send_request(OP_KEY, 8'($urandom));
            end
            calm = 1'b0;
        end

        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/dsfc_pkg.sv
src/dsfc_box_ram.sv
src/dual_sbox_feedback_stream_cipher_core.sv
bench/dsfc_stream_checker.sv
bench/tb_dual_sbox_feedback_stream_cipher_core.sv
